// ===== src/hmenc_pkg.sv =====
// shared types, constants and the code word function for the (16,11) stream encoder
// no dependencies; imported by every module of the block
package hmenc_pkg;

    localparam int GROUP_BITS      = 11;
    localparam int BYTE_BITS       = 8;
    localparam int WORD_BITS       = 16;
    localparam int COUNT_BITS      = 4;
    localparam int TOTAL_BITS      = 5;
    localparam int MERGE_BITS      = GROUP_BITS + BYTE_BITS - 1;
    localparam int QUEUE_DEPTH_DEF = 4;

    // one queue entry: the words that one byte causes
    typedef struct packed {
        logic                  two_words;
        logic                  last0;
        logic [GROUP_BITS-1:0] grp0;
        logic [GROUP_BITS-1:0] grp1;
    } hmenc_job_t;

    // data bits to positions 3,5,6,7,9..15, parity at 1,2,4,8, overall parity at 0
    function automatic logic [WORD_BITS-1:0] hmenc_encode(input logic [GROUP_BITS-1:0] d);
        logic [WORD_BITS-1:0] w;
        w       = '0;
        w[3]    = d[0];
        w[5]    = d[1];
        w[6]    = d[2];
        w[7]    = d[3];
        w[15:9] = d[10:4];
        w[1]    = d[0] ^ d[1] ^ d[3] ^ d[4] ^ d[6] ^ d[8] ^ d[10];
        w[2]    = d[0] ^ d[2] ^ d[3] ^ d[5] ^ d[6] ^ d[9] ^ d[10];
        w[4]    = d[1] ^ d[2] ^ d[3] ^ d[7] ^ d[8] ^ d[9] ^ d[10];
        w[8]    = ^d[10:4];
        w[0]    = ^w[15:1];
        return w;
    endfunction

endpackage

// ===== src/hmenc_front.sv =====
// front end: accepts bytes, packs bits into 11-bit groups and queues the resulting jobs
// depends on hmenc_pkg
module hmenc_front
    import hmenc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_BITS-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  logic                  q_full,
    output logic                  q_push,
    output hmenc_job_t            q_job
);

    logic [GROUP_BITS-1:0] bits_reg, bits_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [MERGE_BITS-1:0] merged;
    logic [TOTAL_BITS-1:0] total;
    logic [TOTAL_BITS-1:0] rem;
    logic                  grp_full;
    logic                  accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        merged   = {{(MERGE_BITS-GROUP_BITS){1'b0}}, bits_reg}
                 | ({{(MERGE_BITS-BYTE_BITS){1'b0}}, s_tdata} << count_reg);
        total    = {{(TOTAL_BITS-COUNT_BITS){1'b0}}, count_reg} + TOTAL_BITS'(BYTE_BITS);
        grp_full = total >= TOTAL_BITS'(GROUP_BITS);
        rem      = grp_full ? total - TOTAL_BITS'(GROUP_BITS) : total;

        q_job.grp0      = merged[GROUP_BITS-1:0];
        q_job.grp1      = {{(2*GROUP_BITS-MERGE_BITS){1'b0}}, merged[MERGE_BITS-1:GROUP_BITS]};
        q_job.last0     = s_tlast && (!grp_full || rem == '0);
        q_job.two_words = s_tlast && grp_full && rem != '0;
        q_push          = accept && (grp_full || s_tlast);

        bits_next  = bits_reg;
        count_next = count_reg;
        if (accept) begin
            if (s_tlast) begin
                bits_next  = '0;
                count_next = '0;
            end else begin
                bits_next  = grp_full ? q_job.grp1 : merged[GROUP_BITS-1:0];
                count_next = rem[COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg  <= '0;
            count_reg <= '0;
        end else begin
            bits_reg  <= bits_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/hmenc_queue.sv =====
// short job queue between front and back ends
// depends on hmenc_pkg
module hmenc_queue
    import hmenc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  hmenc_job_t push_job,
    input  logic       pop,
    output hmenc_job_t head_job,
    output logic       empty,
    output logic       full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hmenc_job_t           mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign empty    = count_reg == '0;
    assign full     = count_reg == CNT_W'(DEPTH);
    assign head_job = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== src/hmenc_back.sv =====
// back end: encodes queued groups into code words and holds the output register
// depends on hmenc_pkg
module hmenc_back
    import hmenc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  hmenc_job_t            q_head,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [WORD_BITS-1:0]  m_tdata,
    output logic                  m_tlast
);

    logic                  valid_reg, valid_next;
    logic [WORD_BITS-1:0]  data_reg, data_next;
    logic                  last_reg, last_next;
    logic                  second_reg, second_next;
    logic [GROUP_BITS-1:0] hold_reg, hold_next;
    logic                  can_load;

    assign can_load = !valid_reg || m_tready;

    always_comb begin
        valid_next  = valid_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        second_next = second_reg;
        hold_next   = hold_reg;
        q_pop       = 1'b0;
        if (can_load) begin
            if (second_reg) begin
                // flushed partial group of a final byte
                valid_next  = 1'b1;
                data_next   = hmenc_encode(hold_reg);
                last_next   = 1'b1;
                second_next = 1'b0;
            end else if (!q_empty) begin
                q_pop       = 1'b1;
                valid_next  = 1'b1;
                data_next   = hmenc_encode(q_head.grp0);
                last_next   = q_head.last0;
                second_next = q_head.two_words;
                hold_next   = q_head.grp1;
            end else begin
                valid_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
        data_reg <= data_next;
        last_reg <= last_next;
        hold_reg <= hold_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== src/hamming_16_11_stream_encoder.sv =====
// top level of the extended hamming (16,11) stream encoder
// depends on hmenc_pkg, hmenc_front, hmenc_queue, hmenc_back
//
// usage
//   slave channel s_*: one byte per transaction, bit 0 is consumed first; s_tlast marks
//   the final byte of a stream. bits are gathered into 11-bit groups across bytes
//   master channel m_*: one 16-bit extended hamming code word per transaction, parity at
//   bits 0,1,2,4,8; m_tlast marks the final word of the stream
//   a final byte flushes any partial group, zero padded, so it always yields a word
// data path and throughput
//   one byte per cycle is accepted while the job queue is not full; the first word a
//   byte causes is written into the job queue on acceptance and then loaded into the
//   back output register, which drives m_*. a final byte that completes a group and
//   leaves bits over causes two words, which the back end issues one after the other,
//   popping no job in between; all other bytes cause at most one. sustained rate is
//   one byte per cycle while m_tready is high, set by the back end's single output register
// stall and reset
//   when m_tready is low the output word holds, the job queue fills and s_tready falls
//   only once QUEUE_DEPTH jobs wait; the front keeps taking bytes until then
//   aresetn (synchronous, active low) empties the queue, drops the output word and
//   clears the partially collected group
module hamming_16_11_stream_encoder
    import hmenc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF   // jobs buffered between front and back
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // byte input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [7:0] data_byte
    input  logic                 s_tlast,    // last_byte
    // code word output channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,    // [15:0] code_word
    output logic                 m_tlast     // last_word
);

    hmenc_job_t push_job;
    hmenc_job_t head_job;
    logic       q_push;
    logic       q_pop;
    logic       q_empty;
    logic       q_full;

    // front: bit packing and job classification
    hmenc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    // decoupling queue so either side may stall on its own
    hmenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back: encoding and output register
    hmenc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (head_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== src/hmenc_checker.sv =====
// port-level checks for the (16,11) stream encoder, bound to the top level
// depends on hmenc_pkg and hamming_16_11_stream_encoder
module hmenc_checker
    import hmenc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    logic [GROUP_BITS-1:0] word_data;

    assign word_data = {m_tdata[15:9], m_tdata[7:5], m_tdata[3]};

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // every word is a valid code word of its own data bits
    a_codeword: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata == hmenc_encode(word_data))
        else $error("output is not a valid code word");

    // no word leaves the block in the cycle after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a byte accepted into an idle block cannot reach the output in the cycle after its acceptance
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !$past(s_tvalid && s_tready) |=> !m_tvalid || $past(m_tvalid) ||
        $past(s_tvalid && s_tready, 2) || $past(m_tvalid, 2) || !$past(aresetn, 2) ||
        $past(s_tvalid && s_tready, 3) || $past(m_tvalid, 3) || !$past(aresetn, 3))
        else $error("word appeared without an earlier byte");

endmodule

bind hamming_16_11_stream_encoder hmenc_checker u_hmenc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
